>>> rtl/gbns_pkg.sv
// Shared types and constants for the go-back-n sender window core.
// Depends on nothing; every other file but gbns_checker imports it.
package gbns_pkg;

	// Window positions and the per-item beat counter (window is at most 7).
	localparam int POS_W      = 3;
	localparam int CHAIN_N    = 8;

	// Widths of the result fields on the ports.
	localparam int OUT_SEQ_W  = 3;
	localparam int OUT_SLOT_W = 8;

	// Widest internal values over the supported parameter ranges.
	localparam int MAX_SEQ_W  = 8;
	localparam int MAX_SLOT_W = 12;
	localparam int MAX_CNT_W  = 13;

	// Entries in the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Request codes on func.
	localparam logic [1:0] FUNC_NEW = 2'd0;
	localparam logic [1:0] FUNC_ACK = 2'd1;
	localparam logic [1:0] FUNC_TMO = 2'd2;

	// How the back end expands one descriptor into result beats.
	typedef enum logic [1:0] {
		MODE_SINGLE,
		MODE_RELEASE,
		MODE_RESEND
	} mode_t;

	// One classified request, as handed from front to back.
	typedef struct packed {
		mode_t                 mode;
		logic [MAX_SEQ_W-1:0]  seq_a;   // send seq (single) or first seq of run
		logic [MAX_SLOT_W-1:0] slot_a;  // slot (single) or first slot of run
		logic [MAX_SEQ_W-1:0]  seq_b;   // seq entering the window on release
		logic [MAX_SLOT_W-1:0] slot_b;  // slot entering the window on release
		logic [MAX_CNT_W-1:0]  cnt;     // queued count before the release
		logic [POS_W-1:0]      rem;     // beats left after the first
		logic                  send_v;
		logic                  acc;
		logic                  full;
	} desc_t;

	// Low bits of a sequence number as shown on the ports.
	function automatic logic [OUT_SEQ_W-1:0] seq_low(input logic [MAX_SEQ_W-1:0] s);
		return s[OUT_SEQ_W-1:0];
	endfunction

	// Low bits of a slot as shown on the ports.
	function automatic logic [OUT_SLOT_W-1:0] slot_low(input logic [MAX_SLOT_W-1:0] s);
		return s[OUT_SLOT_W-1:0];
	endfunction

endpackage

>>> rtl/gbns_front.sv
// Front end: accepts requests, owns the window state, classifies each request
// into one descriptor for the back end. Depends on gbns_pkg.
module gbns_front #(
	parameter int BUFFER_DEPTH = 256,
	parameter int WINDOW_SIZE  = 4,
	parameter int SEQ_MODULUS  = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  logic [1:0]     func,
	input  logic [2:0]     ack_seq,
	input  logic           ack_checksum_ok,
	input  logic [2:0]     timeout_seq,
	input  logic           q_full,
	output logic           push,
	output gbns_pkg::desc_t push_desc
);
	import gbns_pkg::*;

	localparam int SEQ_W  = $clog2(SEQ_MODULUS);
	localparam int SLOT_W = $clog2(BUFFER_DEPTH);
	localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);

	function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
		return (s == SEQ_W'(SEQ_MODULUS - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(BUFFER_DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	logic [SLOT_W-1:0] head_q, head_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [SEQ_W-1:0]  base_q, base_d;
	logic [SEQ_W-1:0]  next_seq_q, next_seq_d;

	logic [SEQ_W-1:0]  seq_chain [CHAIN_N];
	logic [SLOT_W-1:0] slot_chain [CHAIN_N];
	logic [POS_W-1:0]  n_fly;
	logic              ack_hit, to_hit;
	logic [POS_W-1:0]  ack_pos, to_pos;
	logic [CNT_W:0]    tail_sum;
	logic [SLOT_W-1:0] tail_slot;
	desc_t             desc;

	assign req_ready = !q_full;
	assign push      = req_valid && req_ready;
	assign push_desc = desc;

	// Walk sequence numbers and slots across the window positions
	always_comb begin
		seq_chain[0]  = base_q;
		slot_chain[0] = head_q;
		for (int i = 0; i < CHAIN_N - 1; i++) begin
			seq_chain[i+1]  = seq_inc(seq_chain[i]);
			slot_chain[i+1] = slot_inc(slot_chain[i]);
		end
	end

	// Packets in flight
	assign n_fly = (count_q < CNT_W'(WINDOW_SIZE)) ? POS_W'(count_q) : POS_W'(WINDOW_SIZE);

	// Find the first in-flight position matching the ack and timeout numbers
	always_comb begin
		ack_hit = 1'b0;
		ack_pos = '0;
		to_hit  = 1'b0;
		to_pos  = '0;
		for (int i = WINDOW_SIZE - 1; i >= 0; i--) begin
			if (POS_W'(i) < n_fly) begin
				if (seq_low(MAX_SEQ_W'(seq_chain[i])) == ack_seq) begin
					ack_hit = 1'b1;
					ack_pos = POS_W'(i);
				end
				if (seq_low(MAX_SEQ_W'(seq_chain[i])) == timeout_seq) begin
					to_hit = 1'b1;
					to_pos = POS_W'(i);
				end
			end
		end
	end

	// Slot behind the last queued packet
	always_comb begin
		tail_sum  = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
		tail_slot = (tail_sum >= (CNT_W+1)'(BUFFER_DEPTH)) ?
			SLOT_W'(tail_sum - (CNT_W+1)'(BUFFER_DEPTH)) : SLOT_W'(tail_sum);
	end

	// Classify the request and work out the next window state
	always_comb begin
		desc       = '0;
		desc.mode  = MODE_SINGLE;
		desc.full  = count_q == CNT_W'(BUFFER_DEPTH);
		head_d     = head_q;
		count_d    = count_q;
		base_d     = base_q;
		next_seq_d = next_seq_q;
		case (func)
			FUNC_NEW: begin
				if (count_q == CNT_W'(BUFFER_DEPTH)) begin
					desc.full = 1'b1;
				end else begin
					desc.seq_a  = MAX_SEQ_W'(next_seq_q);
					desc.slot_a = MAX_SLOT_W'(tail_slot);
					desc.send_v = count_q < CNT_W'(WINDOW_SIZE);
					desc.acc    = 1'b1;
					desc.full   = count_q == CNT_W'(BUFFER_DEPTH - 1);
					count_d     = count_q + 1'b1;
					next_seq_d  = seq_inc(next_seq_q);
				end
			end
			FUNC_ACK: begin
				if (ack_checksum_ok && ack_hit) begin
					desc.mode   = MODE_RELEASE;
					desc.seq_a  = MAX_SEQ_W'(base_q);
					desc.slot_a = MAX_SLOT_W'(head_q);
					desc.seq_b  = MAX_SEQ_W'(seq_chain[WINDOW_SIZE]);
					desc.slot_b = MAX_SLOT_W'(slot_chain[WINDOW_SIZE]);
					desc.cnt    = MAX_CNT_W'(count_q);
					desc.rem    = ack_pos;
					desc.full   = 1'b0;
					head_d      = slot_chain[ack_pos + 1'b1];
					base_d      = seq_chain[ack_pos + 1'b1];
					count_d     = count_q - (CNT_W'(ack_pos) + CNT_W'(1));
				end
			end
			FUNC_TMO: begin
				if (to_hit) begin
					desc.mode   = MODE_RESEND;
					desc.seq_a  = MAX_SEQ_W'(seq_chain[to_pos]);
					desc.slot_a = MAX_SLOT_W'(slot_chain[to_pos]);
					desc.rem    = n_fly - to_pos - 1'b1;
					desc.full   = count_q == CNT_W'(BUFFER_DEPTH);
				end
			end
			default: begin
				desc.mode = MODE_SINGLE;
			end
		endcase
	end

	// Advance the window state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			base_q     <= '0;
			next_seq_q <= '0;
		end else if (push) begin
			head_q     <= head_d;
			count_q    <= count_d;
			base_q     <= base_d;
			next_seq_q <= next_seq_d;
		end
	end

endmodule

>>> rtl/gbns_queue.sv
// Short descriptor queue between the front and back ends.
// Depends on gbns_pkg.
module gbns_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gbns_pkg::desc_t push_desc,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output gbns_pkg::desc_t head_desc
);
	import gbns_pkg::*;

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	desc_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	assign full      = fill_q == FILL_W'(QUEUE_DEPTH);
	assign valid     = fill_q != '0;
	assign head_desc = entry_q[rd_ptr_q];

	// Store pushed descriptors
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	// Move pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> rtl/gbns_back.sv
// Back end: expands each descriptor into result beats, one per cycle unless
// rsp_ready stalls, through a registered result stage. Depends on gbns_pkg.
module gbns_back #(
	parameter int BUFFER_DEPTH = 256,
	parameter int WINDOW_SIZE  = 4,
	parameter int SEQ_MODULUS  = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  gbns_pkg::desc_t q_desc,
	output logic            q_pop,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output logic            stop_valid,
	output logic [2:0]      stop_seq,
	output logic            send_valid,
	output logic [2:0]      send_seq,
	output logic [7:0]      send_slot,
	output logic            accepted,
	output logic            buffer_full,
	output logic            last
);
	import gbns_pkg::*;

	localparam int SEQ_W  = $clog2(SEQ_MODULUS);
	localparam int SLOT_W = $clog2(BUFFER_DEPTH);

	function automatic logic [MAX_SEQ_W-1:0] seq_inc(input logic [MAX_SEQ_W-1:0] s);
		logic [SEQ_W-1:0] v;
		v = SEQ_W'(s);
		return MAX_SEQ_W'((v == SEQ_W'(SEQ_MODULUS - 1)) ? '0 : v + 1'b1);
	endfunction

	function automatic logic [MAX_SLOT_W-1:0] slot_inc(input logic [MAX_SLOT_W-1:0] s);
		logic [SLOT_W-1:0] v;
		v = SLOT_W'(s);
		return MAX_SLOT_W'((v == SLOT_W'(BUFFER_DEPTH - 1)) ? '0 : v + 1'b1);
	endfunction

	logic                  busy_q, busy_d;
	desc_t                 work_q, work_d;
	logic                  beat_fire, beat_last, load;
	logic                  b_stop, b_send;
	logic [MAX_SEQ_W-1:0]  b_stop_seq, b_send_seq;
	logic [MAX_SLOT_W-1:0] b_slot;

	logic                  rsp_valid_q;
	logic                  stop_valid_q, send_valid_q, accepted_q, buffer_full_q, last_q;
	logic [OUT_SEQ_W-1:0]  stop_seq_q, send_seq_q;
	logic [OUT_SLOT_W-1:0] send_slot_q;

	assign beat_fire = busy_q && (!rsp_valid_q || rsp_ready);
	assign load      = q_valid && (!busy_q || (beat_fire && beat_last));
	assign q_pop     = load;

	// Form the current beat from the working descriptor
	always_comb begin
		b_stop     = 1'b0;
		b_send     = 1'b0;
		b_stop_seq = '0;
		b_send_seq = '0;
		b_slot     = '0;
		beat_last  = work_q.rem == '0;
		case (work_q.mode)
			MODE_SINGLE: begin
				b_send     = work_q.send_v;
				b_send_seq = work_q.seq_a;
				b_slot     = work_q.slot_a;
				beat_last  = 1'b1;
			end
			MODE_RELEASE: begin
				b_stop     = 1'b1;
				b_stop_seq = work_q.seq_a;
				if (work_q.cnt > MAX_CNT_W'(WINDOW_SIZE)) begin
					b_send     = 1'b1;
					b_send_seq = work_q.seq_b;
					b_slot     = work_q.slot_b;
				end
			end
			MODE_RESEND: begin
				b_stop     = 1'b1;
				b_send     = 1'b1;
				b_stop_seq = work_q.seq_a;
				b_send_seq = work_q.seq_a;
				b_slot     = work_q.slot_a;
			end
			default: begin
				beat_last = 1'b1;
			end
		endcase
	end

	// Load, advance or retire the working descriptor
	always_comb begin
		busy_d = busy_q;
		work_d = work_q;
		if (load) begin
			busy_d = 1'b1;
			work_d = q_desc;
		end else if (beat_fire && beat_last) begin
			busy_d = 1'b0;
		end else if (beat_fire) begin
			work_d.seq_a  = seq_inc(work_q.seq_a);
			work_d.slot_a = slot_inc(work_q.slot_a);
			work_d.seq_b  = seq_inc(work_q.seq_b);
			work_d.slot_b = slot_inc(work_q.slot_b);
			work_d.cnt    = work_q.cnt - 1'b1;
			work_d.rem    = work_q.rem - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		work_q <= work_d;
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			busy_q <= busy_d;
			if (beat_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Capture the beat into the result register
	always_ff @(posedge clk) begin
		if (beat_fire) begin
			stop_valid_q  <= b_stop;
			stop_seq_q    <= seq_low(b_stop_seq);
			send_valid_q  <= b_send;
			send_seq_q    <= seq_low(b_send_seq);
			send_slot_q   <= slot_low(b_slot);
			accepted_q    <= work_q.acc && (work_q.mode == MODE_SINGLE);
			buffer_full_q <= work_q.full;
			last_q        <= beat_last;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign stop_valid  = stop_valid_q;
	assign stop_seq    = stop_seq_q;
	assign send_valid  = send_valid_q;
	assign send_seq    = send_seq_q;
	assign send_slot   = send_slot_q;
	assign accepted    = accepted_q;
	assign buffer_full = buffer_full_q;
	assign last        = last_q;

endmodule

>>> rtl/go_back_n_sender_window_core.sv
// Channel  Handshake              Beat contents
// req      req_valid / req_ready  func, ack_seq, ack_checksum_ok, timeout_seq
// rsp      rsp_valid / rsp_ready  stop_valid, stop_seq, send_valid, send_seq,
//                                 send_slot, accepted, buffer_full, last
//
// Each request yields 1 to WINDOW_SIZE result beats; the back end issues one
// beat per cycle while the result side does not stall. The front takes a
// request per cycle while the two-entry descriptor queue has room. No clearing
// pass: the block takes requests as soon as reset is released. Either side may
// stall freely.
// Top level of the go-back-n sender window; depends on gbns_pkg, gbns_front,
// gbns_queue and gbns_back.
module go_back_n_sender_window_core #(
	parameter int BUFFER_DEPTH = 256,
	parameter int WINDOW_SIZE  = 4,
	parameter int SEQ_MODULUS  = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [1:0] func,
	input  logic [2:0] ack_seq,
	input  logic       ack_checksum_ok,
	input  logic [2:0] timeout_seq,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic       stop_valid,
	output logic [2:0] stop_seq,
	output logic       send_valid,
	output logic [2:0] send_seq,
	output logic [7:0] send_slot,
	output logic       accepted,
	output logic       buffer_full,
	output logic       last
);
	import gbns_pkg::*;

	logic  q_full, q_push, q_pop, q_valid;
	desc_t push_desc, head_desc;

	// Classify requests and keep the window state
	gbns_front #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.WINDOW_SIZE (WINDOW_SIZE),
		.SEQ_MODULUS (SEQ_MODULUS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.func           (func),
		.ack_seq        (ack_seq),
		.ack_checksum_ok(ack_checksum_ok),
		.timeout_seq    (timeout_seq),
		.q_full         (q_full),
		.push           (q_push),
		.push_desc      (push_desc)
	);

	// Decouple the two ends
	gbns_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_desc(push_desc),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head_desc(head_desc)
	);

	// Expand descriptors into result beats
	gbns_back #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.WINDOW_SIZE (WINDOW_SIZE),
		.SEQ_MODULUS (SEQ_MODULUS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_desc     (head_desc),
		.q_pop      (q_pop),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.stop_valid (stop_valid),
		.stop_seq   (stop_seq),
		.send_valid (send_valid),
		.send_seq   (send_seq),
		.send_slot  (send_slot),
		.accepted   (accepted),
		.buffer_full(buffer_full),
		.last       (last)
	);

endmodule

>>> rtl/gbns_checker.sv
// Port-level checks for go_back_n_sender_window_core, bound to the top level.
// Depends only on the top level's ports.
module gbns_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic [1:0] func,
	input logic [2:0] ack_seq,
	input logic       ack_checksum_ok,
	input logic [2:0] timeout_seq,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       stop_valid,
	input logic [2:0] stop_seq,
	input logic       send_valid,
	input logic [2:0] send_seq,
	input logic [7:0] send_slot,
	input logic       accepted,
	input logic       buffer_full,
	input logic       last
);

	// Hold a waiting request beat
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(func) && $stable(ack_seq)
			&& $stable(ack_checksum_ok) && $stable(timeout_seq))
		else $error("waiting request beat changed");

	// Hold a stalled result beat
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(stop_seq) && $stable(send_seq)
			&& $stable(send_slot) && $stable(last))
		else $error("stalled result beat changed");

	// A queued new message is a single beat that stops no timer
	a_accept_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && accepted |-> last && !stop_valid)
		else $error("accepted message not a lone beat");

	// Only a new message sends without stopping a timer
	a_send_from_new: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && send_valid && !stop_valid |-> accepted)
		else $error("send without stop outside a new message");

	// A release frees a slot, so the buffer cannot be full
	a_release_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && stop_valid && !send_valid |-> !buffer_full && !accepted)
		else $error("release beat reports a full buffer");

endmodule

bind go_back_n_sender_window_core gbns_checker u_gbns_checker (.*);
